/* design/grs_pkg.sv */
// Shared types, codes and defaults for the graph reachability store.
// No dependencies; every other design file depends on this package.
package grs_pkg;

  localparam int ID_W  = 4;
  localparam int ACT_W = 2;

  localparam int NODE_COUNT_DEF = 16;
  localparam int COUNT_BITS_DEF = 4;

  typedef logic [ACT_W-1:0] act_t;
  typedef logic [ID_W-1:0]  id_t;

  localparam act_t ACT_ADD_EDGE = 2'd0;
  localparam act_t ACT_REM_EDGE = 2'd1;
  localparam act_t ACT_REM_NODE = 2'd2;
  localparam act_t ACT_QUERY    = 2'd3;

  typedef logic [1:0] rd_src_t;

  localparam rd_src_t RD_NODE_A = 2'd0;
  localparam rd_src_t RD_NODE_B = 2'd1;
  localparam rd_src_t RD_CNT    = 2'd2;
  localparam rd_src_t RD_PICK   = 2'd3;

  typedef struct packed {
    logic    load;
    logic    rd_en;
    rd_src_t rd_src;
    logic    wr_en;
    logic    wr_zero;
    logic    col_b;
    logic    dec;
    logic    cnt_clr;
    logic    cnt_inc;
    logic    q_init;
    logic    q_pick;
    logic    q_merge;
    logic    set_reach;
    logic    out_load;
  } cmd_t;

  typedef struct packed {
    act_t act;
    logic ok;
    logic same_ab;
    logic cnt_is_a;
    logic cnt_last;
    logic seen_b;
    logic avail_any;
  } sts_t;

endpackage

/* design/grs_if.sv */
// Valid/ready channel interfaces for the graph reachability store.
// Depends on grs_pkg for field widths.
interface grs_in_if;
  logic             valid;
  logic             ready;
  grs_pkg::act_t    action;
  grs_pkg::id_t     node_a;
  grs_pkg::id_t     node_b;

  modport source (output valid, output action, output node_a, output node_b, input ready);
  modport sink   (input valid, input action, input node_a, input node_b, output ready);
endinterface

interface grs_out_if;
  logic valid;
  logic ready;
  logic reachable;
  logic count_saturated;

  modport source (output valid, output reachable, output count_saturated, input ready);
  modport sink   (input valid, input reachable, input count_saturated, output ready);
endinterface

/* design/grs_dp.sv */
// Datapath: item registers, edge-count row memory, node counter,
// reached/visited sets and result registers. Depends on grs_pkg.
module grs_dp #(
  parameter int NODE_COUNT = 16,
  parameter int COUNT_BITS = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  grs_pkg::act_t       in_action,
  input  grs_pkg::id_t        in_node_a,
  input  grs_pkg::id_t        in_node_b,
  input  grs_pkg::cmd_t       cmd,
  output grs_pkg::sts_t       sts,
  output logic                out_reachable,
  output logic                out_count_saturated
);
  import grs_pkg::*;

  localparam int IW = $clog2(NODE_COUNT);
  localparam int RW = NODE_COUNT * COUNT_BITS;
  localparam int XW = ID_W + IW;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;

  act_t                  act_r;
  id_t                   a_r;
  id_t                   b_r;
  logic [RW-1:0]         row_mem_r [NODE_COUNT];
  logic [NODE_COUNT-1:0] row_vld_r;
  logic [RW-1:0]         rd_row_r;
  logic                  rd_vld_r;
  logic [IW-1:0]         rd_idx_r;
  logic [IW-1:0]         cnt_r;
  logic [NODE_COUNT-1:0] seen_r;
  logic [NODE_COUNT-1:0] done_r;
  logic                  reach_r;
  logic                  sat_r;
  logic                  out_reach_r;
  logic                  out_sat_r;

  logic [XW-1:0]         a_x;
  logic [XW-1:0]         b_x;
  logic                  a_ok;
  logic                  b_ok;
  logic [IW-1:0]         a_idx;
  logic [IW-1:0]         b_idx;
  logic [IW-1:0]         rd_idx;
  logic [IW-1:0]         wr_idx;
  logic [IW-1:0]         col_idx;
  logic [IW-1:0]         pick_idx;
  logic [NODE_COUNT-1:0] avail;
  logic [NODE_COUNT-1:0] nz;
  logic [RW-1:0]         eff_row;
  logic [RW-1:0]         mod_row;
  logic [RW-1:0]         wr_data;
  logic [COUNT_BITS-1:0] cur;
  logic [COUNT_BITS-1:0] new_cnt;
  logic                  cur_max;

  assign a_x   = XW'(a_r);
  assign b_x   = XW'(b_r);
  assign a_ok  = a_x < XW'(NODE_COUNT);
  assign b_ok  = b_x < XW'(NODE_COUNT);
  assign a_idx = a_x[IW-1:0];
  assign b_idx = b_x[IW-1:0];

  always_comb begin
    unique case (cmd.rd_src)
      RD_NODE_A: rd_idx = a_idx;
      RD_NODE_B: rd_idx = b_idx;
      RD_CNT:    rd_idx = cnt_r;
      RD_PICK:   rd_idx = pick_idx;
      default:   rd_idx = a_idx;
    endcase
  end

  assign avail = seen_r & ~done_r;

  always_comb begin
    pick_idx = '0;
    for (int i = NODE_COUNT - 1; i >= 0; i--) begin
      if (avail[i]) begin
        pick_idx = IW'(i);
      end
    end
  end

  assign eff_row = rd_vld_r ? rd_row_r : '0;
  assign col_idx = cmd.col_b ? b_idx : a_idx;
  assign cur     = eff_row[col_idx*COUNT_BITS +: COUNT_BITS];
  assign cur_max = (cur == COUNT_MAX);

  always_comb begin
    if (cmd.dec) begin
      new_cnt = (cur != '0) ? cur - COUNT_BITS'(1) : cur;
    end else begin
      new_cnt = cur_max ? cur : cur + COUNT_BITS'(1);
    end
  end

  always_comb begin
    for (int c = 0; c < NODE_COUNT; c++) begin
      mod_row[c*COUNT_BITS +: COUNT_BITS] = (col_idx == IW'(c)) ? new_cnt
                                          : eff_row[c*COUNT_BITS +: COUNT_BITS];
      nz[c] = |eff_row[c*COUNT_BITS +: COUNT_BITS];
    end
  end

  assign wr_data = cmd.wr_zero ? '0 : mod_row;
  assign wr_idx  = cmd.wr_zero ? a_idx : rd_idx_r;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      row_mem_r[wr_idx] <= wr_data;
    end
    if (cmd.rd_en) begin
      rd_row_r <= row_mem_r[rd_idx];
      rd_vld_r <= row_vld_r[rd_idx];
      rd_idx_r <= rd_idx;
    end
    if (cmd.load) begin
      act_r <= in_action;
      a_r   <= in_node_a;
      b_r   <= in_node_b;
    end
    if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + IW'(1);
    end
    if (cmd.q_init) begin
      seen_r <= NODE_COUNT'(1) << a_idx;
      done_r <= '0;
    end else begin
      if (cmd.q_pick) begin
        done_r[pick_idx] <= 1'b1;
      end
      if (cmd.q_merge) begin
        seen_r <= seen_r | nz;
      end
    end
    if (cmd.load) begin
      reach_r <= 1'b0;
      sat_r   <= 1'b0;
    end else begin
      if (cmd.set_reach) begin
        reach_r <= 1'b1;
      end
      if (cmd.wr_en && !cmd.wr_zero && !cmd.dec && cur_max) begin
        sat_r <= 1'b1;
      end
    end
    if (cmd.out_load) begin
      out_reach_r <= reach_r;
      out_sat_r   <= sat_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_vld_r <= '0;
    end else if (cmd.wr_en) begin
      row_vld_r[wr_idx] <= 1'b1;
    end
  end

  always_comb begin
    sts.act       = act_r;
    sts.ok        = (act_r == ACT_REM_NODE) ? a_ok : (a_ok && b_ok);
    sts.same_ab   = (a_r == b_r);
    sts.cnt_is_a  = (cnt_r == a_idx);
    sts.cnt_last  = (cnt_r == IW'(NODE_COUNT - 1));
    sts.seen_b    = seen_r[b_idx];
    sts.avail_any = |avail;
  end

  assign out_reachable       = out_reach_r;
  assign out_count_saturated = out_sat_r;

endmodule

/* design/grs_ctrl.sv */
// Controller state machine: sequences row reads and writes for each action
// and owns the channel handshakes. Depends on grs_pkg.
module grs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  grs_pkg::sts_t sts,
  output grs_pkg::cmd_t cmd
);
  import grs_pkg::*;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DEC    = 4'd1;
  localparam logic [3:0] S_E_RD   = 4'd2;
  localparam logic [3:0] S_E_WR   = 4'd3;
  localparam logic [3:0] S_N_CLR  = 4'd4;
  localparam logic [3:0] S_N_RD   = 4'd5;
  localparam logic [3:0] S_N_WR   = 4'd6;
  localparam logic [3:0] S_Q_INIT = 4'd7;
  localparam logic [3:0] S_Q_PICK = 4'd8;
  localparam logic [3:0] S_Q_MRG  = 4'd9;
  localparam logic [3:0] S_FIN    = 4'd10;

  logic [3:0] state_r;
  logic [3:0] state_nxt;
  logic       phase_r;
  logic       phase_nxt;
  logic       out_valid_r;
  logic       out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cmd       = '0;
    in_ready  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        if (!sts.ok) begin
          state_nxt = S_FIN;
        end else begin
          unique case (sts.act)
            ACT_ADD_EDGE, ACT_REM_EDGE: begin
              phase_nxt = 1'b0;
              state_nxt = S_E_RD;
            end
            ACT_REM_NODE: state_nxt = S_N_CLR;
            ACT_QUERY: begin
              if (sts.same_ab) begin
                cmd.set_reach = 1'b1;
                state_nxt     = S_FIN;
              end else begin
                state_nxt = S_Q_INIT;
              end
            end
            default: state_nxt = S_FIN;
          endcase
        end
      end
      S_E_RD: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_src = phase_r ? RD_NODE_B : RD_NODE_A;
        state_nxt  = S_E_WR;
      end
      S_E_WR: begin
        cmd.wr_en = 1'b1;
        cmd.col_b = !phase_r;
        cmd.dec   = (sts.act == ACT_REM_EDGE);
        if (!phase_r) begin
          phase_nxt = 1'b1;
          state_nxt = S_E_RD;
        end else begin
          state_nxt = S_FIN;
        end
      end
      S_N_CLR: begin
        cmd.wr_en   = 1'b1;
        cmd.wr_zero = 1'b1;
        cmd.cnt_clr = 1'b1;
        state_nxt   = S_N_RD;
      end
      S_N_RD: begin
        if (sts.cnt_is_a) begin
          cmd.cnt_inc = 1'b1;
          if (sts.cnt_last) begin
            state_nxt = S_FIN;
          end
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_CNT;
          state_nxt  = S_N_WR;
        end
      end
      S_N_WR: begin
        cmd.wr_en   = 1'b1;
        cmd.dec     = 1'b1;
        cmd.cnt_inc = 1'b1;
        state_nxt   = sts.cnt_last ? S_FIN : S_N_RD;
      end
      S_Q_INIT: begin
        cmd.q_init = 1'b1;
        state_nxt  = S_Q_PICK;
      end
      S_Q_PICK: begin
        if (sts.seen_b) begin
          cmd.set_reach = 1'b1;
          state_nxt     = S_FIN;
        end else if (!sts.avail_any) begin
          state_nxt = S_FIN;
        end else begin
          cmd.rd_en  = 1'b1;
          cmd.rd_src = RD_PICK;
          cmd.q_pick = 1'b1;
          state_nxt  = S_Q_MRG;
        end
      end
      S_Q_MRG: begin
        cmd.q_merge = 1'b1;
        state_nxt   = S_Q_PICK;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  assign out_valid_nxt = cmd.out_load || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      phase_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      phase_r     <= phase_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

/* design/graph_reachability_store_top.sv */
// Add/remove edge updates the row of node_a, then the row of node_b; remove node
// clears the row of node_a, then decrements column node_a of every other row; a path
// query does one row read and merge per node visited, and start equal to target is
// reachable without a search. One transaction is handled at a time: the next is
// taken while the result waits, and a stalled result holds the following one in S_FIN.
// Reset is synchronous: per-row valid bits clear, so the store reads empty at once.
module graph_reachability_store_top #(
  parameter int NODE_COUNT = grs_pkg::NODE_COUNT_DEF,
  parameter int COUNT_BITS = grs_pkg::COUNT_BITS_DEF
) (
  input  logic   clk,
  input  logic   rst_n,
  grs_in_if.sink   in_ch,
  grs_out_if.source out_ch
);
  import grs_pkg::*;

  cmd_t cmd;
  sts_t sts;

  grs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  grs_dp #(
    .NODE_COUNT (NODE_COUNT),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_action           (in_ch.action),
    .in_node_a           (in_ch.node_a),
    .in_node_b           (in_ch.node_b),
    .cmd                 (cmd),
    .sts                 (sts),
    .out_reachable       (out_ch.reachable),
    .out_count_saturated (out_ch.count_saturated)
  );

endmodule
